@@ hw/rtl/tps_pkg.sv @@
// ----------------------------------------------------------------------------
// tps_pkg
// shared types, constants and vertex order for the thick polyline stroker
// ----------------------------------------------------------------------------
`default_nettype none
package tps_pkg;

  localparam int VERT_W  = 25;
  localparam int KIND_W  = 2;
  localparam int LANE_W  = 4;
  localparam int COLOR_W = 2;
  localparam int SCALE_W = 12;
  localparam int HW_NUM  = 165;
  localparam int DEN_SH  = 4;
  localparam int Q_BITS  = 10;
  localparam int OFS_W   = 12;
  localparam int CH_W    = 16;
  localparam int IDX_W   = 3;

  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ROAD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RIVER   = 2'd2;

  localparam logic [COLOR_W-1:0] COLOR_NONE  = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_BLUE  = 2'd2;

  localparam logic [IDX_W-1:0] IDX_CONNECT = 3'd0;
  localparam logic [IDX_W-1:0] IDX_QUAD    = 3'd2;
  localparam logic [IDX_W-1:0] IDX_QUAD_END = 3'd5;
  localparam logic [IDX_W-1:0] IDX_TAIL_END = 3'd7;

  typedef enum logic [1:0] {
    MUL_SQX,
    MUL_SQY,
    MUL_NUM,
    MUL_RHS
  } mul_sel_t;

  typedef struct packed {
    logic             capture;
    logic             store_first;
    logic             mul_load;
    mul_sel_t         mul_sel;
    logic             mul_step;
    logic             sq_save;
    logic             axis;
    logic             root_init;
    logic             root_cand;
    logic             root_cmp;
    logic             offs;
    logic             vert_load;
    logic [IDX_W-1:0] vert_idx;
    logic             vert_end;
    logic             commit;
  } cmd_t;

  typedef struct packed {
    logic mul_last;
    logic prod_zero;
    logic bit_zero;
  } status_t;

  // vertex built on the current point rather than the stored one
  function automatic logic vtx_next(input logic [IDX_W-1:0] idx);
    logic r;
    case (idx) inside
      3'd3, 3'd4, 3'd6, 3'd7: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  // vertex takes the offset added rather than subtracted
  function automatic logic vtx_plus(input logic [IDX_W-1:0] idx);
    logic r;
    case (idx) inside
      3'd1, 3'd2, 3'd3, 3'd6: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tps_if.sv @@
// ----------------------------------------------------------------------------
// tps_if
// valid/ready channels for points in and vertices out
// ----------------------------------------------------------------------------
`default_nettype none
interface tps_point_if #(parameter int COORD_BITS = 24);
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS-1:0]      pos_x;
  logic signed [COORD_BITS-1:0]      pos_y;
  logic [tps_pkg::KIND_W-1:0]        way_kind;
  logic [tps_pkg::LANE_W-1:0]        lane_units;
  logic                              first_point;
  logic                              last_point;
  modport source (output valid, pos_x, pos_y, way_kind, lane_units, first_point,
                  last_point, input ready);
  modport sink (input valid, pos_x, pos_y, way_kind, lane_units, first_point,
                last_point, output ready);
endinterface

interface tps_vert_if;
  logic                              valid;
  logic                              ready;
  logic signed [tps_pkg::VERT_W-1:0] vert_x;
  logic signed [tps_pkg::VERT_W-1:0] vert_y;
  logic [tps_pkg::COLOR_W-1:0]       color_code;
  logic                              run_end;
  modport source (output valid, vert_x, vert_y, color_code, run_end, input ready);
  modport sink (input valid, vert_x, vert_y, color_code, run_end, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tps_ctrl.sv @@
// ----------------------------------------------------------------------------
// tps_ctrl
// sequencer: difference squares, two root searches, vertex emission
// ----------------------------------------------------------------------------
`default_nettype none
module tps_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [tps_pkg::KIND_W-1:0] way_kind,
  input  wire logic                       first_point,
  input  wire logic                       last_point,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output tps_pkg::cmd_t                   cmd,
  input  wire tps_pkg::status_t           status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_STEP,
    S_ZCHK,
    S_RINIT,
    S_CAND,
    S_CMP,
    S_OFFS,
    S_EMIT
  } state_t;

  state_t                      state;
  tps_pkg::mul_sel_t           mphase;
  logic                        axis;
  logic                        seen;
  logic                        last_r;
  logic [tps_pkg::IDX_W-1:0]   idx;
  logic [tps_pkg::IDX_W-1:0]   idx_end;
  logic                        accept;
  logic                        emit_go;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_end  = last_r ? tps_pkg::IDX_QUAD_END : tps_pkg::IDX_TAIL_END;
  assign emit_go  = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    cmd             = '0;
    cmd.axis        = axis;
    cmd.mul_sel     = mphase;
    cmd.vert_idx    = idx;
    cmd.vert_end    = (idx == idx_end);
    case (state)
      S_IDLE: begin
        cmd.capture     = accept;
        cmd.store_first = accept && first_point && (way_kind != tps_pkg::KIND_UNKNOWN);
      end
      S_LOAD:  cmd.mul_load  = 1'b1;
      S_STEP:  cmd.mul_step  = 1'b1;
      S_ZCHK:  cmd.sq_save   = 1'b1;
      S_RINIT: cmd.root_init = 1'b1;
      S_CAND:  cmd.root_cand = 1'b1;
      S_CMP:   cmd.root_cmp  = 1'b1;
      S_OFFS:  cmd.offs      = 1'b1;
      S_EMIT: begin
        cmd.vert_load = emit_go;
        cmd.commit    = emit_go && (idx == idx_end);
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mphase    <= tps_pkg::MUL_SQX;
      axis      <= 1'b0;
      seen      <= 1'b0;
      last_r    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (way_kind != tps_pkg::KIND_UNKNOWN)) begin
            if (first_point) begin
              seen <= 1'b0;
            end else begin
              last_r <= last_point;
              mphase <= tps_pkg::MUL_SQX;
              state  <= S_LOAD;
            end
          end
        end
        S_LOAD: state <= S_STEP;
        S_STEP: begin
          if (status.mul_last) begin
            case (mphase)
              tps_pkg::MUL_SQX: begin
                mphase <= tps_pkg::MUL_SQY;
                state  <= S_LOAD;
              end
              tps_pkg::MUL_SQY: state <= S_ZCHK;
              tps_pkg::MUL_NUM: begin
                mphase <= tps_pkg::MUL_RHS;
                state  <= S_LOAD;
              end
              default: state <= S_RINIT;
            endcase
          end
        end
        S_ZCHK: begin
          axis <= 1'b0;
          if (status.prod_zero) begin
            state <= S_OFFS;
          end else begin
            mphase <= tps_pkg::MUL_NUM;
            state  <= S_LOAD;
          end
        end
        S_RINIT: state <= S_CAND;
        S_CAND:  state <= S_CMP;
        S_CMP: begin
          if (!status.bit_zero) begin
            state <= S_CAND;
          end else if (!axis) begin
            axis   <= 1'b1;
            mphase <= tps_pkg::MUL_NUM;
            state  <= S_LOAD;
          end else begin
            state <= S_OFFS;
          end
        end
        S_OFFS: begin
          idx   <= seen ? tps_pkg::IDX_CONNECT : tps_pkg::IDX_QUAD;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            if (idx == idx_end) begin
              seen  <= !last_r;
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tps_dp.sv @@
// ----------------------------------------------------------------------------
// tps_dp
// datapath: chunked multiplier, bit-serial root search, vertex builder
// ----------------------------------------------------------------------------
`default_nettype none
module tps_dp #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tps_pkg::cmd_t                 cmd,
  output tps_pkg::status_t                   status,
  input  wire logic signed [COORD_BITS-1:0]  pos_x,
  input  wire logic signed [COORD_BITS-1:0]  pos_y,
  input  wire logic [tps_pkg::KIND_W-1:0]    way_kind,
  input  wire logic [tps_pkg::LANE_W-1:0]    lane_units,
  output logic signed [tps_pkg::VERT_W-1:0]  vert_x,
  output logic signed [tps_pkg::VERT_W-1:0]  vert_y,
  output logic [tps_pkg::COLOR_W-1:0]        color_code,
  output logic                               run_end
);

  localparam int MAG_W  = COORD_BITS + 1;
  localparam int DIF_W  = COORD_BITS + 2;
  localparam int NUM_W  = MAG_W + tps_pkg::SCALE_W;
  localparam int PROD_W = 2 * NUM_W;
  localparam int NCH    = (NUM_W + tps_pkg::CH_W - 1) / tps_pkg::CH_W;
  localparam int MB_W   = NCH * tps_pkg::CH_W;
  localparam int K_W    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PP_W   = NUM_W + tps_pkg::CH_W;
  localparam int SQ_W   = 2 * MAG_W + 1;
  localparam int B_W    = SQ_W + tps_pkg::Q_BITS;
  localparam int ACC_W  = SQ_W + 2 * tps_pkg::Q_BITS;
  localparam int CMP_W  = ACC_W + tps_pkg::DEN_SH;
  localparam int BIT_W  = $clog2(tps_pkg::Q_BITS);
  localparam int SUM_W  = (COORD_BITS + 2 > tps_pkg::VERT_W) ? COORD_BITS + 2
                                                             : tps_pkg::VERT_W;

  logic signed [COORD_BITS-1:0]       prev_x, prev_y, cur_x, cur_y;
  logic [MAG_W-1:0]                   mag_x, mag_y;
  logic                               dx_neg, dy_pos;
  logic [tps_pkg::SCALE_W-1:0]        scale;
  logic [tps_pkg::COLOR_W-1:0]        color;
  logic signed [DIF_W-1:0]            dx_c, dy_c;

  logic [NUM_W-1:0]                   ma;
  logic [MB_W-1:0]                    mb;
  logic [K_W-1:0]                     mk;
  logic [PROD_W-1:0]                  prod;
  logic [tps_pkg::CH_W-1:0]           chunk;
  logic [PP_W-1:0]                    pp;

  logic [SQ_W-1:0]                    sq;
  logic                               zero_len;
  logic [PROD_W-1:0]                  rhs;
  logic [ACC_W-1:0]                   acc_a, cand;
  logic [B_W-1:0]                     acc_b;
  logic [BIT_W-1:0]                   bitn;
  logic [tps_pkg::Q_BITS-1:0]         q_y, q_x;
  logic signed [tps_pkg::OFS_W-1:0]   xo, yo;

  logic                               use_n, plus;
  logic signed [SUM_W-1:0]            bx, by, ox, oy, sx, sy;

  assign dx_c = DIF_W'(pos_x) - DIF_W'(prev_x);
  assign dy_c = DIF_W'(pos_y) - DIF_W'(prev_y);

  assign chunk = mb[mk*tps_pkg::CH_W +: tps_pkg::CH_W];
  assign pp    = PP_W'(ma) * PP_W'(chunk);

  assign status.mul_last  = (mk == K_W'(NCH - 1));
  assign status.prod_zero = (prod == '0);
  assign status.bit_zero  = (bitn == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (cmd.store_first || cmd.commit) begin
      prev_x <= cmd.commit ? cur_x : pos_x;
      prev_y <= cmd.commit ? cur_y : pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_x  <= pos_x;
      cur_y  <= pos_y;
      mag_x  <= dx_c[DIF_W-1] ? MAG_W'(-dx_c) : MAG_W'(dx_c);
      mag_y  <= dy_c[DIF_W-1] ? MAG_W'(-dy_c) : MAG_W'(dy_c);
      dx_neg <= dx_c[DIF_W-1];
      dy_pos <= !dy_c[DIF_W-1] && (dy_c != '0);
      scale  <= tps_pkg::SCALE_W'(tps_pkg::HW_NUM) * tps_pkg::SCALE_W'(lane_units);
      color  <= (way_kind == tps_pkg::KIND_ROAD)  ? tps_pkg::COLOR_BLACK :
                (way_kind == tps_pkg::KIND_RIVER) ? tps_pkg::COLOR_BLUE  :
                                                    tps_pkg::COLOR_NONE;
    end

    if (cmd.mul_load) begin
      mk <= '0;
      case (cmd.mul_sel)
        tps_pkg::MUL_SQX: begin
          ma   <= NUM_W'(mag_x);
          mb   <= MB_W'(mag_x);
          prod <= '0;
        end
        tps_pkg::MUL_SQY: begin
          ma <= NUM_W'(mag_y);
          mb <= MB_W'(mag_y);
        end
        tps_pkg::MUL_NUM: begin
          ma   <= NUM_W'(scale);
          mb   <= cmd.axis ? MB_W'(mag_x) : MB_W'(mag_y);
          prod <= '0;
        end
        default: begin
          ma   <= prod[NUM_W-1:0];
          mb   <= MB_W'(prod[NUM_W-1:0]);
          prod <= '0;
        end
      endcase
    end else if (cmd.mul_step) begin
      prod <= prod + (PROD_W'(pp) << (mk * tps_pkg::CH_W));
      mk   <= mk + 1'b1;
    end

    if (cmd.sq_save) begin
      sq       <= prod[SQ_W-1:0];
      zero_len <= (prod == '0);
    end

    if (cmd.root_init) begin
      rhs   <= prod;
      acc_a <= '0;
      acc_b <= '0;
      bitn  <= BIT_W'(tps_pkg::Q_BITS - 1);
      if (cmd.axis) q_x <= '0;
      else          q_y <= '0;
    end

    if (cmd.root_cand)
      cand <= acc_a + (ACC_W'(acc_b) << (bitn + 1'b1)) + (ACC_W'(sq) << {bitn, 1'b0});

    if (cmd.root_cmp) begin
      if ({cand, tps_pkg::DEN_SH'(0)} <= CMP_W'(rhs)) begin
        acc_a <= cand;
        acc_b <= acc_b + (B_W'(sq) << bitn);
        if (cmd.axis) q_x[bitn] <= 1'b1;
        else          q_y[bitn] <= 1'b1;
      end
      if (bitn != '0)
        bitn <= bitn - 1'b1;
    end

    if (cmd.offs) begin
      if (zero_len) begin
        xo <= '0;
        yo <= tps_pkg::OFS_W'(scale >> 2);
      end else begin
        xo <= dy_pos ? -tps_pkg::OFS_W'(q_y) : tps_pkg::OFS_W'(q_y);
        yo <= dx_neg ? -tps_pkg::OFS_W'(q_x) : tps_pkg::OFS_W'(q_x);
      end
    end

    if (cmd.vert_load) begin
      vert_x     <= sx[tps_pkg::VERT_W-1:0];
      vert_y     <= sy[tps_pkg::VERT_W-1:0];
      color_code <= color;
      run_end    <= cmd.vert_end;
    end
  end

  always_comb begin
    use_n = tps_pkg::vtx_next(cmd.vert_idx);
    plus  = tps_pkg::vtx_plus(cmd.vert_idx);
    bx    = use_n ? SUM_W'(cur_x) : SUM_W'(prev_x);
    by    = use_n ? SUM_W'(cur_y) : SUM_W'(prev_y);
    ox    = SUM_W'(xo);
    oy    = SUM_W'(yo);
    sx    = plus ? bx + ox : bx - ox;
    sy    = plus ? by + oy : by - oy;
  end

endmodule
`default_nettype wire

@@ hw/rtl/thick_polyline_stroker_core.sv @@
// ----------------------------------------------------------------------------
// thick_polyline_stroker_core
// turns polyline points into quad-strip vertices of a constant-width stroke
//
//   channel  role  word
//   in_ch    sink  one point: position, way kind, lane units, first/last
//   out_ch   src   one vertex: position, color, run end
//
// a segment point squares both differences, runs two 10-step root searches
// and emits V = 4 to 8 vertices; the multiplier works in
// N = ceil((COORD_BITS+13)/16) chunks of 16 bits
// a zero-length segment skips the root searches
// first points and unknown ways start no sequence; reset clears the stored point
// a stalled output holds the vertex register and the sequencer waits on it
// ----------------------------------------------------------------------------
`default_nettype none
module thick_polyline_stroker_core #(
  parameter int COORD_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  tps_point_if.sink in_ch,
  tps_vert_if.source out_ch
);

  tps_pkg::cmd_t    cmd;
  tps_pkg::status_t status;

  tps_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .way_kind    (in_ch.way_kind),
    .first_point (in_ch.first_point),
    .last_point  (in_ch.last_point),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .status      (status)
  );

  tps_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .pos_x      (in_ch.pos_x),
    .pos_y      (in_ch.pos_y),
    .way_kind   (in_ch.way_kind),
    .lane_units (in_ch.lane_units),
    .vert_x     (out_ch.vert_x),
    .vert_y     (out_ch.vert_y),
    .color_code (out_ch.color_code),
    .run_end    (out_ch.run_end)
  );

endmodule
`default_nettype wire

@@ verif/thick_polyline_stroker_core_tb.sv @@
// ----------------------------------------------------------------------------
// thick_polyline_stroker_core_tb
// drives points into the stroker and checks every emitted vertex against an
// in-bench stroke predictor; directed table first, then random polylines
// ----------------------------------------------------------------------------
module thick_polyline_stroker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 24;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [tps_pkg::VERT_W-1:0]  x;
    logic signed [tps_pkg::VERT_W-1:0]  y;
    logic [tps_pkg::COLOR_W-1:0]        color;
    logic                               rend;
  } vertex_t;

  typedef struct {
    logic signed [CB-1:0]          px;
    logic signed [CB-1:0]          py;
    logic [tps_pkg::KIND_W-1:0]    kind;
    logic [tps_pkg::LANE_W-1:0]    lanes;
    logic                          first;
    logic                          last;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  tps_point_if #(.COORD_BITS(CB)) in_ch ();
  tps_vert_if out_ch ();

  thick_polyline_stroker_core #(.COORD_BITS(CB)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  vertex_t vert_queue[$];
  logic signed [CB-1:0] last_x, last_y;
  logic strip_open;
  int errors;
  int stall_cycles;
  bit calm;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] offset_root(input logic [63:0] num,
                                              input logic [127:0] sq);
    logic [127:0] rhs;
    logic [63:0] q, t;
    rhs = 128'(num) * 128'(num);
    q = 0;
    for (int b = tps_pkg::Q_BITS - 1; b >= 0; b--) begin
      t = q | (64'd1 << b);
      if (sq * 128'(16 * t * t) <= rhs) q = t;
    end
    return q;
  endfunction

  task automatic stroke_predict(input point_t p);
    longint dx, dy, xo, yo, lx, ly, nx, ny, sc, adx, ady;
    logic [127:0] sq;
    logic [tps_pkg::COLOR_W-1:0] c;
    if (p.kind == tps_pkg::KIND_UNKNOWN) return;
    if (p.first) begin
      last_x = p.px; last_y = p.py; strip_open = 0;
      return;
    end
    c = (p.kind == tps_pkg::KIND_ROAD)  ? tps_pkg::COLOR_BLACK :
        (p.kind == tps_pkg::KIND_RIVER) ? tps_pkg::COLOR_BLUE  : tps_pkg::COLOR_NONE;
    nx = p.px; ny = p.py; lx = last_x; ly = last_y;
    dx = nx - lx; dy = ny - ly;
    adx = dx < 0 ? -dx : dx; ady = dy < 0 ? -dy : dy;
    sc = tps_pkg::HW_NUM * p.lanes;
    sq = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
    if (sq == 0) begin
      xo = 0; yo = sc / 4;
    end else begin
      xo = offset_root(sc * ady, sq);
      yo = offset_root(sc * adx, sq);
      if (dy > 0) xo = -xo;
      if (dx < 0) yo = -yo;
    end
    if (strip_open) begin
      vert_queue.push_back({tps_pkg::VERT_W'(lx - xo), tps_pkg::VERT_W'(ly - yo), c, 1'b0});
      vert_queue.push_back({tps_pkg::VERT_W'(lx + xo), tps_pkg::VERT_W'(ly + yo), c, 1'b0});
    end
    vert_queue.push_back({tps_pkg::VERT_W'(lx + xo), tps_pkg::VERT_W'(ly + yo), c, 1'b0});
    vert_queue.push_back({tps_pkg::VERT_W'(nx + xo), tps_pkg::VERT_W'(ny + yo), c, 1'b0});
    vert_queue.push_back({tps_pkg::VERT_W'(nx - xo), tps_pkg::VERT_W'(ny - yo), c, 1'b0});
    vert_queue.push_back({tps_pkg::VERT_W'(lx - xo), tps_pkg::VERT_W'(ly - yo), c, p.last});
    if (!p.last) begin
      vert_queue.push_back({tps_pkg::VERT_W'(nx + xo), tps_pkg::VERT_W'(ny + yo), c, 1'b0});
      vert_queue.push_back({tps_pkg::VERT_W'(nx - xo), tps_pkg::VERT_W'(ny - yo), c, 1'b1});
    end
    last_x = p.px; last_y = p.py; strip_open = !p.last;
  endtask

  // output side: random stalls, compare on accept
  always @(posedge clk) begin
    vertex_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.vert_x, out_ch.vert_y, out_ch.color_code, out_ch.run_end};
        if (vert_queue.size() == 0) begin
          report("unexpected word", got.x, 0);
        end else begin
          want = vert_queue.pop_front();
          if (got.x !== want.x) report("vert_x", got.x, want.x);
          if (got.y !== want.y) report("vert_y", got.y, want.y);
          if (got.color !== want.color) report("color_code", got.color, want.color);
          if (got.rend !== want.rend) report("run_end", got.rend, want.rend);
        end
      end
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 4) != 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("** thick_polyline_stroker_core: FAILED **");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  task automatic send_point(input point_t p);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= p.px; in_ch.pos_y <= p.py;
    in_ch.way_kind <= p.kind; in_ch.lane_units <= p.lanes;
    in_ch.first_point <= p.first; in_ch.last_point <= p.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    stroke_predict(p);
  endtask

  function automatic point_t mk(input int x, input int y, input int k, input int l,
                                input bit f, input bit e);
    point_t p;
    p.px = CB'(x); p.py = CB'(y);
    p.kind = tps_pkg::KIND_W'(k); p.lanes = tps_pkg::LANE_W'(l);
    p.first = f; p.last = e;
    return p;
  endfunction

  function automatic int rnd_coord();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 32'hFFFFFF) << 8) >>> 8;
      1: return $urandom_range(0, 2000) - 1000;
      2: return $urandom_range(0, 1) ? 8388607 - $urandom_range(0, 50)
                                     : -8388608 + $urandom_range(0, 50);
      default: return $urandom_range(0, 20) - 10;
    endcase
  endfunction

  point_t dir_tab[$];
  int n_items;
  int k, npts;
  point_t p;

  initial begin
    errors = 0; calm = 0; strip_open = 0; last_x = 0; last_y = 0;
    in_ch.valid = 0; in_ch.pos_x = 0; in_ch.pos_y = 0; in_ch.way_kind = 0;
    in_ch.lane_units = 0; in_ch.first_point = 0; in_ch.last_point = 0;
    // point without a first point after reset, unknown way, zero length, extremes
    dir_tab = '{
      mk(100, 0, 1, 4, 0, 0), mk(5, 5, 0, 4, 1, 1),
      mk(100, 0, 2, 4, 0, 1), mk(7, 7, 3, 2, 1, 1),
      mk(0, 0, 1, 12, 1, 0), mk(0, 0, 1, 12, 0, 0),
      mk(0, 300, 2, 0, 0, 0), mk(-300, 300, 3, 15, 0, 0),
      mk(8388607, 8388607, 1, 12, 0, 0), mk(-8388608, -8388608, 2, 1, 0, 0),
      mk(8388607, -8388608, 1, 13, 0, 1), mk(-8388608, 8388607, 1, 12, 1, 0),
      mk(8388607, -8388608, 2, 12, 0, 0), mk(3, 4, 0, 9, 0, 0),
      mk(3, 4, 1, 6, 0, 1), mk(10, 10, 1, 3, 0, 0)
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) send_point(dir_tab[i]);
    // hold off until the stroker drains
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (vert_queue.size() != 0);
    n_items = 0;
    while (n_items < 370) begin
      if (n_items > 320) calm = 1;
      npts = $urandom_range(2, 6);
      for (k = 0; k < npts; k++) begin
        p = mk(rnd_coord(), rnd_coord(), $urandom_range(1, 3),
               $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 12),
               k == 0, k == npts - 1);
        if ($urandom_range(0, 9) == 0) begin
          p.kind = tps_pkg::KIND_W'($urandom_range(0, 3));
          p.first = 1'($urandom_range(0, 1));
          p.last = 1'($urandom_range(0, 1));
        end
        send_point(p);
        if (p.kind != tps_pkg::KIND_UNKNOWN) n_items++;
      end
    end
    in_ch.valid <= 1'b0;
    while (vert_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("** thick_polyline_stroker_core: PASSED **");
    else $display("** thick_polyline_stroker_core: FAILED **");
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/tps_pkg.sv
hw/rtl/tps_if.sv
hw/rtl/tps_ctrl.sv
hw/rtl/tps_dp.sv
hw/rtl/thick_polyline_stroker_core.sv
verif/thick_polyline_stroker_core_tb.sv
